FILE: rtl/core/ldpcge_pkg.sv
package ldpcge_pkg;

  // Default sizes of the generator store
  localparam int unsigned MAX_MSG_BYTES_DEF   = 32;
  localparam int unsigned MAX_PARITY_BITS_DEF = 256;

  // Fixed field widths
  localparam int unsigned ROW_W       = 8;
  localparam int unsigned COL_W       = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned MSG_FIELD_W = 6;
  localparam int unsigned PAR_FIELD_W = 9;
  localparam int unsigned MODE_W      = 2;

  // Register indices of the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_MODE    = 2'd2;

  // Systematic modes
  localparam logic [MODE_W-1:0] MODE_PARITY_ONLY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MSG_FIRST    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PARITY_FIRST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED     = 2'd3;

  // Input commands carried on tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MSG  = 1'b1;

  // Control that travels with one generator byte read
  typedef struct packed {
    logic valid;
    logic first_col;
    logic last_col;
    logic last_row;
  } mac_ctrl_t;

endpackage

FILE: rtl/core/ldpcge_gen_mac.sv
// Generator store plus the GF(2) row product: one generator byte a cycle is
// ANDed with the matching message byte, folded to one bit and accumulated per
// row. Finished rows are packed MSB first into parity bytes.
module ldpcge_gen_mac #(
  parameter int unsigned MAX_MSG_BYTES   = ldpcge_pkg::MAX_MSG_BYTES_DEF,
  parameter int unsigned MAX_PARITY_BITS = ldpcge_pkg::MAX_PARITY_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [$clog2(MAX_PARITY_BITS)-1:0] wr_row_i,
  input  logic [((MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1)-1:0] wr_col_i,
  input  logic [ldpcge_pkg::BYTE_W-1:0]      wr_data_i,
  input  ldpcge_pkg::mac_ctrl_t              rd_ctrl_i,
  input  logic [$clog2(MAX_PARITY_BITS)-1:0] rd_row_i,
  input  logic [((MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1)-1:0] rd_col_i,
  input  logic [ldpcge_pkg::BYTE_W-1:0]      msg_byte_i,
  output logic                               par_we_o,
  output logic [((((MAX_PARITY_BITS + 7) / 8) > 1) ?
                 $clog2((MAX_PARITY_BITS + 7) / 8) : 1)-1:0] par_addr_o,
  output logic [ldpcge_pkg::BYTE_W-1:0]      par_byte_o
);

  localparam int unsigned RW    = $clog2(MAX_PARITY_BITS);
  localparam int unsigned CW    = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int unsigned NPB   = (MAX_PARITY_BITS + 7) / 8;
  localparam int unsigned PB_W  = (NPB > 1) ? $clog2(NPB) : 1;
  localparam int unsigned DEPTH = 2 ** (RW + CW);

  logic [ldpcge_pkg::BYTE_W-1:0] gen_mem [DEPTH];
  logic [ldpcge_pkg::BYTE_W-1:0] gen_rdata_q;
  ldpcge_pkg::mac_ctrl_t         ctrl_q;
  logic [RW-1:0]                 row_q;
  logic                          acc_q;
  logic [ldpcge_pkg::BYTE_W-1:0] byte_q;

  logic                          bit_val;
  logic [2:0]                    bit_pos;
  logic [ldpcge_pkg::BYTE_W-1:0] byte_new;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      gen_mem[{wr_row_i, wr_col_i}] <= wr_data_i;
    end
    gen_rdata_q <= gen_mem[{rd_row_i, rd_col_i}];
  end

  // The message byte arrives from the caller's buffer with the same latency.
  assign bit_val = (ctrl_q.first_col ? 1'b0 : acc_q) ^ (^(gen_rdata_q & msg_byte_i));
  assign bit_pos = row_q[2:0];

  always_comb begin
    byte_new = (bit_pos == 3'd0) ? '0 : byte_q;
    if (bit_val) begin
      byte_new = byte_new | (8'h80 >> bit_pos);
    end
  end

  assign par_we_o   = ctrl_q.valid && ctrl_q.last_col &&
                      ((bit_pos == 3'd7) || ctrl_q.last_row);
  assign par_addr_o = PB_W'(row_q >> 3);
  assign par_byte_o = byte_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= rd_ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= rd_row_i;
    if (ctrl_q.valid) begin
      acc_q <= bit_val;
      if (ctrl_q.last_col) begin
        byte_q <= byte_new;
      end
    end
  end

endmodule

FILE: rtl/core/ldpc_generator_encoder.sv
// Sequencing: a load or a message byte that does not complete a codeword is
// taken in idle. The completing byte starts the row products, one generator byte
// at a time through the single read port of the generator store, then a drain
// state; every codeword byte then passes the read, load and output states, held
// in output while it stalls. Throughput: one item at a time, taken only in idle.
// Reset: asynchronous, active low; control and configuration clear, memories do not.
module ldpc_generator_encoder #(
  parameter int unsigned MAX_MSG_BYTES   = ldpcge_pkg::MAX_MSG_BYTES_DEF,
  parameter int unsigned MAX_PARITY_BITS = ldpcge_pkg::MAX_PARITY_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream. tdata: row [7:0], col [12:8], data [20:13], zero [23:21]
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [ldpcge_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: cmd [0]
  input  logic                               s_axis_tuser_i,
  // Output stream. tdata: out_byte [7:0]
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [ldpcge_pkg::BYTE_W-1:0]      m_axis_tdata_o,
  // tuser: is_parity [0]
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ldpcge_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ldpcge_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned RW   = $clog2(MAX_PARITY_BITS);
  localparam int unsigned CW   = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int unsigned NPB  = (MAX_PARITY_BITS + 7) / 8;
  localparam int unsigned PB_W = (NPB > 1) ? $clog2(NPB) : 1;
  localparam int unsigned IX_W = (CW > PB_W) ? CW : PB_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_RD,
    ST_LD,
    ST_OUT
  } state_e;

  typedef enum logic {
    SEG_MSG,
    SEG_PAR
  } seg_e;

  // Configuration. Lengths are held saturated and minus one, so that they
  // compare directly against the counters.
  logic [CW-1:0]                 msg_m1_q;
  logic [RW-1:0]                 par_m1_q;
  logic [ldpcge_pkg::MODE_W-1:0] sys_mode_q;

  logic [ldpcge_pkg::MSG_FIELD_W-1:0] cfg_msg_v;
  logic [ldpcge_pkg::PAR_FIELD_W-1:0] cfg_par_v;
  logic [ldpcge_pkg::MODE_W-1:0]      cfg_mode_v;

  assign cfg_ready_o = 1'b1;
  assign cfg_msg_v   = cfg_data_i[ldpcge_pkg::MSG_FIELD_W-1:0];
  assign cfg_par_v   = cfg_data_i[ldpcge_pkg::PAR_FIELD_W-1:0];
  assign cfg_mode_v  = cfg_data_i[ldpcge_pkg::MODE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_m1_q   <= CW'(MAX_MSG_BYTES - 1);
      par_m1_q   <= RW'(MAX_PARITY_BITS - 1);
      sys_mode_q <= ldpcge_pkg::MODE_PARITY_ONLY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ldpcge_pkg::CFG_MSG_BYTES: begin
          if (cfg_msg_v == '0) begin
            msg_m1_q <= '0;
          end else if (cfg_msg_v > ldpcge_pkg::MSG_FIELD_W'(MAX_MSG_BYTES)) begin
            msg_m1_q <= CW'(MAX_MSG_BYTES - 1);
          end else begin
            msg_m1_q <= CW'(cfg_msg_v - 1'b1);
          end
        end
        ldpcge_pkg::CFG_PARITY_BITS: begin
          if (cfg_par_v == '0) begin
            par_m1_q <= '0;
          end else if (cfg_par_v > ldpcge_pkg::PAR_FIELD_W'(MAX_PARITY_BITS)) begin
            par_m1_q <= RW'(MAX_PARITY_BITS - 1);
          end else begin
            par_m1_q <= RW'(cfg_par_v - 1'b1);
          end
        end
        ldpcge_pkg::CFG_SYS_MODE: begin
          // The reserved mode behaves as parity only.
          sys_mode_q <= (cfg_mode_v == ldpcge_pkg::MODE_RESERVED) ?
                        ldpcge_pkg::MODE_PARITY_ONLY : cfg_mode_v;
        end
        default: begin
        end
      endcase
    end
  end

  // Input field unpacking
  logic                          in_fire;
  logic [ldpcge_pkg::ROW_W-1:0]  in_row;
  logic [ldpcge_pkg::COL_W-1:0]  in_col;
  logic [ldpcge_pkg::BYTE_W-1:0] in_data;
  logic                          load_fire;
  logic                          msg_fire;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_row    = s_axis_tdata_i[7:0];
  assign in_col    = s_axis_tdata_i[12:8];
  assign in_data   = s_axis_tdata_i[20:13];
  // Loads outside the store are dropped.
  assign load_fire = in_fire && (s_axis_tuser_i == ldpcge_pkg::CMD_LOAD) &&
                     ({1'b0, in_row} < 9'(MAX_PARITY_BITS)) &&
                     ({1'b0, in_col} < 6'(MAX_MSG_BYTES));
  assign msg_fire  = in_fire && (s_axis_tuser_i == ldpcge_pkg::CMD_MSG);

  // Sequencer state
  state_e                        state_q;
  logic [CW-1:0]                 msg_count_q;
  logic [RW-1:0]                 r_q;
  logic [CW-1:0]                 i_q;
  seg_e                          seg_q;
  logic [IX_W-1:0]               idx_q;
  logic                          out_valid_q;
  logic [ldpcge_pkg::BYTE_W-1:0] out_data_q;
  logic                          out_user_q;
  logic                          out_last_q;
  logic                          sent_last_q;

  // Message buffer and parity byte memory, both with registered reads.
  logic [ldpcge_pkg::BYTE_W-1:0] msg_mem [MAX_MSG_BYTES];
  logic [ldpcge_pkg::BYTE_W-1:0] par_mem [NPB];
  logic [ldpcge_pkg::BYTE_W-1:0] msg_rdata_q;
  logic [ldpcge_pkg::BYTE_W-1:0] par_rdata_q;
  logic [CW-1:0]                 msg_raddr;

  // Row product unit interface
  ldpcge_pkg::mac_ctrl_t         mac_ctrl;
  logic                          mac_par_we;
  logic [PB_W-1:0]               mac_par_addr;
  logic [ldpcge_pkg::BYTE_W-1:0] mac_par_byte;

  assign msg_raddr = (state_q == ST_CALC) ? i_q : idx_q[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (msg_fire) begin
      msg_mem[msg_count_q] <= in_data;
    end
    msg_rdata_q <= msg_mem[msg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mac_par_we) begin
      par_mem[mac_par_addr] <= mac_par_byte;
    end
    par_rdata_q <= par_mem[idx_q[PB_W-1:0]];
  end

  // One generator byte is read per cycle while the row product runs; the
  // message byte at the same column leaves the buffer in the same cycle.
  always_comb begin
    mac_ctrl           = '0;
    mac_ctrl.valid     = (state_q == ST_CALC);
    mac_ctrl.first_col = (i_q == '0);
    mac_ctrl.last_col  = (i_q == msg_m1_q);
    mac_ctrl.last_row  = (r_q == par_m1_q);
  end

  ldpcge_gen_mac #(
    .MAX_MSG_BYTES  (MAX_MSG_BYTES),
    .MAX_PARITY_BITS(MAX_PARITY_BITS)
  ) u_gen_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_fire),
    .wr_row_i  (RW'(in_row)),
    .wr_col_i  (CW'(in_col)),
    .wr_data_i (in_data),
    .rd_ctrl_i (mac_ctrl),
    .rd_row_i  (r_q),
    .rd_col_i  (i_q),
    .msg_byte_i(msg_rdata_q),
    .par_we_o  (mac_par_we),
    .par_addr_o(mac_par_addr),
    .par_byte_o(mac_par_byte)
  );

  // Emission order: mode one sends the message then the parity, mode two the
  // parity then the message, parity only sends just the parity bytes.
  logic [PB_W-1:0] npb_m1;
  logic            seg_end;
  logic            final_seg;

  assign npb_m1    = PB_W'(par_m1_q >> 3);
  assign seg_end   = (seg_q == SEG_MSG) ? (idx_q == IX_W'(msg_m1_q)) :
                                          (idx_q == IX_W'(npb_m1));
  assign final_seg = (sys_mode_q == ldpcge_pkg::MODE_PARITY_FIRST) ?
                     (seg_q == SEG_MSG) : (seg_q == SEG_PAR);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      msg_count_q <= '0;
      r_q         <= '0;
      i_q         <= '0;
      seg_q       <= SEG_PAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
      out_last_q  <= 1'b0;
      sent_last_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (msg_fire) begin
            // A shortened length completes the codeword at once.
            if (msg_count_q >= msg_m1_q) begin
              msg_count_q <= '0;
              r_q         <= '0;
              i_q         <= '0;
              state_q     <= ST_CALC;
            end else begin
              msg_count_q <= msg_count_q + 1'b1;
            end
          end
        end
        ST_CALC: begin
          if (i_q == msg_m1_q) begin
            i_q <= '0;
            if (r_q == par_m1_q) begin
              state_q <= ST_DRAIN;
            end else begin
              r_q <= r_q + 1'b1;
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          // The final row is folded and written to the parity memory here.
          seg_q   <= (sys_mode_q == ldpcge_pkg::MODE_MSG_FIRST) ? SEG_MSG : SEG_PAR;
          idx_q   <= '0;
          state_q <= ST_RD;
        end
        ST_RD: begin
          state_q <= ST_LD;
        end
        ST_LD: begin
          out_valid_q <= 1'b1;
          out_data_q  <= (seg_q == SEG_MSG) ? msg_rdata_q : par_rdata_q;
          out_user_q  <= (seg_q == SEG_PAR);
          out_last_q  <= final_seg && seg_end;
          sent_last_q <= final_seg && seg_end;
          if (seg_end) begin
            idx_q <= '0;
            seg_q <= (seg_q == SEG_MSG) ? SEG_PAR : SEG_MSG;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= sent_last_q ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // Input is never taken while a codeword byte is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input accepted while output pending");

  // Parity bytes are written only while rows are being computed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_par_we |-> (state_q == ST_CALC || state_q == ST_DRAIN))
    else $error("parity write outside row computation");

  // The column counter never passes the message length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (i_q <= msg_m1_q))
    else $error("column index beyond message length");

  // With the message first, the codeword ends on a parity byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o &&
     sys_mode_q == ldpcge_pkg::MODE_MSG_FIRST) |-> m_axis_tuser_o)
    else $error("codeword ends on a message byte in message-first mode");
`endif

endmodule

FILE: dv/tb_ldpc_generator_encoder.sv
module tb_ldpc_generator_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ldpcge_pkg::*;

  // The configuration channel has a fourth index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  localparam int STORE_DEPTH  = MAX_PARITY_BITS_DEF * MAX_MSG_BYTES_DEF;
  localparam int RAND_ITEMS   = 210;
  // Quiet cycles that must pass before a register write. A generator load
  // keeps the block in idle, so this is ample.
  localparam int HOLD_CYCLES  = 16;
  // Ample for the row products and the drain of our largest codeword.
  localparam int DRAIN_CYCLES = 1000;
  localparam int CYCLE_LIMIT  = 5000000;

  // Idle percentages per phase: sender first, then receiver.
  localparam int TX_IDLE_PCT [3] = '{22, 74, 0};
  localparam int RX_IDLE_PCT [3] = '{74, 22, 0};

  // One pending transaction for the driver: an input item or a register write.
  typedef struct packed {
    logic                  is_cfg;
    logic                  cmd;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [BYTE_W-1:0]     data;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic [1:0]            phase;
  } enc_op_t;

  // One expected codeword byte on the output stream.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_parity;
    logic              last;
  } cw_byte_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [BYTE_W-1:0]     m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  enc_op_t  enc_ops[$];
  cw_byte_t codeword_q[$];
  int       errors   = 0;
  int       quiet    = 0;
  int       cycles   = 0;
  logic [1:0] tx_phase = 2'd0;

  // Mirror of the block: registers as written, generator store, message buffer.
  logic [MSG_FIELD_W-1:0] msg_len_reg = 6'd32;
  logic [PAR_FIELD_W-1:0] par_len_reg = 9'd256;
  logic [MODE_W-1:0]      mode_reg    = MODE_PARITY_ONLY;
  logic [BYTE_W-1:0]      gen_mem [STORE_DEPTH];
  logic [BYTE_W-1:0]      msg_buf [MAX_MSG_BYTES_DEF];
  int                     msg_cnt = 0;

  // Stimulus planning state: effective lengths, byte count and which store
  // entries have been loaded, so that no unwritten generator byte is ever read.
  int         plan_kb    = MAX_MSG_BYTES_DEF;
  int         plan_nb    = MAX_PARITY_BITS_DEF;
  int         plan_cnt   = 0;
  logic [1:0] plan_phase = 2'd0;
  bit         loaded [STORE_DEPTH];

  ldpc_generator_encoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Lengths outside the legal range are saturated by the block.
  function automatic int clamp_len(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MSG_BYTES:   msg_len_reg = val[MSG_FIELD_W-1:0];
      CFG_PARITY_BITS: par_len_reg = val[PAR_FIELD_W-1:0];
      CFG_SYS_MODE:    mode_reg    = val[MODE_W-1:0];
      default: ;
    endcase
  endfunction

  // Takes one accepted input item and appends the codeword bytes it causes.
  // Registers are taken as they stand when the byte arrives, so a length
  // changed half way through a codeword acts on the very next message byte.
  function automatic void encode_item(logic cmd, logic [ROW_W-1:0] row,
                                      logic [COL_W-1:0] col, logic [BYTE_W-1:0] data);
    int                           kb;
    int                           nb;
    int                           npb;
    int                           total;
    int                           n;
    logic [MODE_W-1:0]            mode;
    logic [BYTE_W-1:0]            acc;
    logic [BYTE_W-1:0]            pb;
    logic [MAX_PARITY_BITS_DEF-1:0] par_bits;
    if (cmd == CMD_LOAD) begin
      gen_mem[int'(row) * MAX_MSG_BYTES_DEF + int'(col)] = data;
      return;
    end
    kb = clamp_len(int'(msg_len_reg), MAX_MSG_BYTES_DEF);
    if (msg_cnt < MAX_MSG_BYTES_DEF) msg_buf[msg_cnt] = data;
    msg_cnt++;
    if (msg_cnt < kb) return;
    msg_cnt = 0;

    nb   = clamp_len(int'(par_len_reg), MAX_PARITY_BITS_DEF);
    npb  = (nb + 7) / 8;
    mode = (mode_reg == MODE_RESERVED) ? MODE_PARITY_ONLY : mode_reg;

    // Each kept parity bit is the parity of the message masked by its row.
    par_bits = '0;
    for (int r = 0; r < nb; r++) begin
      acc = '0;
      for (int i = 0; i < kb; i++) acc ^= msg_buf[i] & gen_mem[r * MAX_MSG_BYTES_DEF + i];
      par_bits[r] = ^acc;
    end

    total = npb + ((mode == MODE_PARITY_ONLY) ? 0 : kb);
    n     = 0;
    if (mode == MODE_MSG_FIRST) begin
      for (int i = 0; i < kb; i++) begin
        codeword_q.push_back('{msg_buf[i], 1'b0, (n + 1 == total)});
        n++;
      end
    end
    // Parity bits go out most significant bit first; bits beyond the kept
    // count stay zero, which pads the final byte.
    for (int i = 0; i < npb; i++) begin
      for (int j = 0; j < 8; j++) pb[7-j] = par_bits[i*8 + j];
      codeword_q.push_back('{pb, 1'b1, (n + 1 == total)});
      n++;
    end
    if (mode == MODE_PARITY_FIRST) begin
      for (int i = 0; i < kb; i++) begin
        codeword_q.push_back('{msg_buf[i], 1'b0, (n + 1 == total)});
        n++;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    enc_op_t op;
    op         = '0;
    op.is_cfg  = 1'b1;
    op.cfg_idx = idx;
    op.cfg_val = val;
    op.phase   = plan_phase;
    enc_ops.push_back(op);
    case (idx)
      CFG_MSG_BYTES:   plan_kb = clamp_len(int'(val[MSG_FIELD_W-1:0]), MAX_MSG_BYTES_DEF);
      CFG_PARITY_BITS: plan_nb = clamp_len(int'(val[PAR_FIELD_W-1:0]), MAX_PARITY_BITS_DEF);
      default: ;
    endcase
  endtask

  task automatic queue_load(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [BYTE_W-1:0] data);
    enc_op_t op;
    op       = '0;
    op.cmd   = CMD_LOAD;
    op.row   = row;
    op.col   = col;
    op.data  = data;
    op.phase = plan_phase;
    enc_ops.push_back(op);
    loaded[int'(row) * MAX_MSG_BYTES_DEF + int'(col)] = 1'b1;
  endtask

  // A message byte that completes a codeword reads every kept row over the
  // message length, so any entry of that area not yet loaded is loaded first.
  task automatic queue_msg(logic [BYTE_W-1:0] data);
    enc_op_t op;
    bit      completes;
    completes = (plan_cnt + 1 >= plan_kb);
    if (completes) begin
      for (int r = 0; r < plan_nb; r++) begin
        for (int c = 0; c < plan_kb; c++) begin
          if (!loaded[r * MAX_MSG_BYTES_DEF + c])
            queue_load(ROW_W'(r), COL_W'(c), BYTE_W'($urandom_range(255)));
        end
      end
    end
    op       = '0;
    op.cmd   = CMD_MSG;
    op.data  = data;
    op.phase = plan_phase;
    enc_ops.push_back(op);
    plan_cnt = completes ? 0 : plan_cnt + 1;
  endtask

  // Picks a code shape that keeps the row-product time short: mostly short
  // messages with modest parity, sometimes the widest parity with a one-byte
  // message, sometimes long messages with few parity bits. Raw register values
  // beyond the legal range and junk in the unused data bits are mixed in.
  task automatic plan_random_code();
    int                    sel;
    int                    kb;
    int                    nb;
    logic [CFG_DATA_W-1:0] msg_raw;
    logic [CFG_DATA_W-1:0] par_raw;
    sel = $urandom_range(99);
    if (sel < 70) begin
      kb = $urandom_range(1, 4);
      nb = $urandom_range(1, 64);
    end else if (sel < 85) begin
      kb = 1;
      nb = $urandom_range(65, 256);
    end else begin
      kb = $urandom_range(5, 32);
      nb = $urandom_range(1, 4);
    end
    msg_raw = {3'($urandom_range(7)), 6'(kb)};
    if (kb == 32 && $urandom_range(1) == 1) msg_raw[5:0] = 6'($urandom_range(33, 63));
    if (kb == 1 && $urandom_range(3) == 0) msg_raw[5:0] = '0;
    par_raw = 9'(nb);
    if (nb == 256 && $urandom_range(1) == 1) par_raw = 9'($urandom_range(257, 511));
    if (nb == 1 && $urandom_range(3) == 0) par_raw = '0;
    queue_cfg(CFG_MSG_BYTES, msg_raw);
    queue_cfg(CFG_PARITY_BITS, par_raw);
    queue_cfg(CFG_SYS_MODE, {7'($urandom_range(127)), 2'($urandom_range(3))});
    if ($urandom_range(7) == 0) queue_cfg(CFG_NONE, 9'($urandom_range(511)));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the head of the pending queue on the input stream or on
  // the configuration channel. Register writes wait until no codeword byte is
  // outstanding and nothing has moved on any channel for a while.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive
    logic    in_hs;
    logic    cfg_hs;
    logic    out_hs;
    logic    nxt_in;
    logic    nxt_cfg;
    enc_op_t head;
    in_hs  = s_axis_tvalid_i && s_axis_tready_o;
    cfg_hs = cfg_valid_i && cfg_ready_o;
    out_hs = m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni) begin
      quiet <= (in_hs || cfg_hs || out_hs) ? 0 : quiet + 1;
      if (in_hs || cfg_hs) void'(enc_ops.pop_front());
      // A transaction on offer stays untouched until it is accepted.
      if (!((s_axis_tvalid_i && !in_hs) || (cfg_valid_i && !cfg_hs))) begin
        nxt_in  = 1'b0;
        nxt_cfg = 1'b0;
        if (enc_ops.size() != 0) begin
          head = enc_ops[0];
          if (head.is_cfg) begin
            nxt_cfg = !(in_hs || cfg_hs || out_hs) && quiet >= HOLD_CYCLES &&
                      codeword_q.size() == 0;
          end else begin
            nxt_in = $urandom_range(99) >= TX_IDLE_PCT[head.phase];
          end
          s_axis_tdata_i <= {3'b000, head.data, head.col, head.row};
          s_axis_tuser_i <= head.cmd;
          cfg_index_i    <= head.cfg_idx;
          cfg_data_i     <= head.cfg_val;
          tx_phase       <= head.phase;
        end
        s_axis_tvalid_i <= nxt_in;
        cfg_valid_i     <= nxt_cfg;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the output at random, keeps the mirror in step with every
  // accepted transaction and checks each codeword byte against the oldest one
  // expected.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch
    cw_byte_t want;
    if (rst_ni) begin
      m_axis_tready_i <= $urandom_range(99) >= RX_IDLE_PCT[tx_phase];
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (codeword_q.size() == 0) begin
          errors++;
          $display("%0t: codeword byte with none expected, expected nothing, actual %h/%b/%b",
                   $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        end else begin
          want = codeword_q.pop_front();
          check_field("out_byte", want.out_byte, m_axis_tdata_o);
          check_field("is_parity", BYTE_W'(want.is_parity), BYTE_W'(m_axis_tuser_o));
          check_field("last", BYTE_W'(want.last), BYTE_W'(m_axis_tlast_o));
        end
      end
      if (cfg_valid_i && cfg_ready_o) apply_cfg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o)
        encode_item(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[12:8],
                    s_axis_tdata_i[20:13]);
    end
  end

  // Hang guard: far beyond the slowest correct run of this stimulus.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_ldpc_generator_encoder: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------

  initial begin
    // Directed part. The register index with no register behind it first,
    // then corners of the store.
    queue_cfg(CFG_NONE, 9'h1FF);
    queue_load(8'hFF, 5'h1F, 8'hFF);
    queue_load(8'h00, 5'h00, 8'h00);

    // One-byte messages in every systematic mode, with a part-filled final
    // parity byte.
    queue_cfg(CFG_MSG_BYTES, 9'd1);
    queue_cfg(CFG_PARITY_BITS, 9'd13);
    queue_cfg(CFG_SYS_MODE, 9'(MODE_MSG_FIRST));
    queue_msg(8'hFF);
    queue_msg(8'h00);
    queue_cfg(CFG_SYS_MODE, 9'(MODE_PARITY_FIRST));
    queue_msg(8'h5A);
    queue_cfg(CFG_SYS_MODE, {7'h7F, MODE_RESERVED});
    queue_msg(8'hA5);

    // Both lengths written as zero saturate to one.
    queue_cfg(CFG_MSG_BYTES, 9'h1C0);
    queue_cfg(CFG_PARITY_BITS, 9'd0);
    queue_cfg(CFG_SYS_MODE, 9'(MODE_MSG_FIRST));
    queue_msg(8'h81);

    // Widest parity, then an oversized parity length that saturates to it.
    queue_cfg(CFG_MSG_BYTES, 9'd1);
    queue_cfg(CFG_PARITY_BITS, 9'd256);
    queue_msg(8'hFF);
    queue_cfg(CFG_PARITY_BITS, 9'h1FF);
    queue_cfg(CFG_SYS_MODE, 9'(MODE_PARITY_ONLY));
    queue_msg(8'h3C);

    // Message length cut below the bytes already taken mid-codeword: the
    // next byte closes the codeword.
    queue_cfg(CFG_PARITY_BITS, 9'd16);
    queue_cfg(CFG_MSG_BYTES, 9'd4);
    queue_cfg(CFG_SYS_MODE, 9'(MODE_PARITY_FIRST));
    queue_msg(8'h12);
    queue_msg(8'h34);
    queue_cfg(CFG_MSG_BYTES, 9'd2);
    queue_msg(8'h56);
    // Message length raised mid-codeword.
    queue_msg(8'h78);
    queue_cfg(CFG_MSG_BYTES, 9'd3);
    queue_msg(8'h9A);
    queue_msg(8'hBC);

    // Random part, in three idling phases. It opens with the longest message,
    // written as an oversized length.
    queue_cfg(CFG_MSG_BYTES, 9'h03F);
    queue_cfg(CFG_PARITY_BITS, 9'd2);
    queue_cfg(CFG_SYS_MODE, 9'(MODE_MSG_FIRST));
    for (int k = 0; k < RAND_ITEMS; k++) begin
      plan_phase = 2'(k * 3 / RAND_ITEMS);
      if ($urandom_range(11) == 0) plan_random_code();
      if ($urandom_range(99) < 15)
        queue_load(8'($urandom_range(255)), 5'($urandom_range(31)), 8'($urandom_range(255)));
      else
        queue_msg(8'($urandom_range(255)));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (enc_ops.size() != 0 || codeword_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && codeword_q.size() == 0)
      $display("tb_ldpc_generator_encoder: clean");
    else
      $display("tb_ldpc_generator_encoder: errors");
    $finish;
  end

endmodule
